// ===== src/mamdani_fuzzy_infer_centroid_defines.svh =====
// assertion macros shared by the checker of the fuzzy inference block
`ifndef MAMDANI_FUZZY_INFER_CENTROID_DEFINES_SVH
`define MAMDANI_FUZZY_INFER_CENTROID_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MFIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MFIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mfic_pkg.sv =====
// shared constants, item types and controller/datapath interface types
package mfic_pkg;

    localparam int MAX_RULES  = 16;
    localparam int RULE_W     = $clog2(MAX_RULES);
    localparam int NR_W       = 5;
    localparam int COORD_W    = 16;
    localparam int MU_W       = 16;
    localparam int SETS       = 3;
    localparam int TBL_DEPTH  = MAX_RULES * SETS;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);
    localparam int ENTRY_W    = 4 * COORD_W + MU_W;
    localparam int SAMP_W     = 8;
    localparam int SUM_W      = 25;
    localparam int NUM_W      = 34;
    localparam int NS_W       = SUM_W + SAMP_W;
    localparam int RN_W       = 50;
    localparam int DIV_DW     = 51;
    localparam int DIV_VW     = 34;
    localparam int DIV_CW     = $clog2(DIV_DW + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // divider step counts for each use
    localparam logic [DIV_CW-1:0] DIV_STEPS_MEM = DIV_CW'(32);
    localparam logic [DIV_CW-1:0] DIV_STEPS_X   = DIV_CW'(24);
    localparam logic [DIV_CW-1:0] DIV_STEPS_FIN = DIV_CW'(DIV_DW);

    // item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // set codes
    localparam logic [1:0] SET_A = 2'd0;
    localparam logic [1:0] SET_B = 2'd1;
    localparam logic [1:0] SET_C = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RULES_IN_USE = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         rule_index;
        logic [1:0]         which_set;
        logic signed [15:0] corner_one;
        logic signed [15:0] corner_two;
        logic signed [15:0] corner_three;
        logic signed [15:0] corner_four;
        logic [15:0]        set_height;
        logic signed [15:0] crisp_a;
        logic signed [15:0] crisp_b;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] centroid_value;
        logic               empty_area;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] c1;
        logic signed [COORD_W-1:0] c2;
        logic signed [COORD_W-1:0] c3;
        logic signed [COORD_W-1:0] c4;
        logic [MU_W-1:0]           h;
    } trap_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RES_EMPTY,
        OP_RD,
        OP_MEM,
        OP_MEM_WAIT,
        OP_SAVE_A,
        OP_ALPHA,
        OP_CLIP,
        OP_XDIV,
        OP_XWAIT,
        OP_ACCUM,
        OP_FIN1,
        OP_FIN2,
        OP_FIN3,
        OP_FIN_WAIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic                accept;
        logic                out_load;
        logic [1:0]          phase;
        logic [RULE_W-1:0]   rule;
        logic [SAMP_W-1:0]   idx;
    } dp_cmd_t;

    typedef struct packed {
        logic              div_done;
        logic              mem_div;
        logic              trivial;
        logic              sum_zero;
        logic [NR_W-1:0]   rules;
        logic [SAMP_W-1:0] samples;
    } dp_status_t;

endpackage

// ===== src/mfic_ram.sv =====
// generic single write port ram with registered read
module mfic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mfic_div.sv =====
// shared restoring divider, one quotient bit per cycle
module mfic_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mfic_pkg::DIV_CW-1:0] steps,
    input  logic [mfic_pkg::DIV_DW-1:0] dividend,
    input  logic [mfic_pkg::DIV_VW-1:0] divisor,
    output logic                        done,
    output logic [mfic_pkg::DIV_DW-1:0] quotient
);
    import mfic_pkg::*;

    logic [DIV_DW-1:0] q_reg, q_next;
    logic [DIV_VW-1:0] r_reg, r_next;
    logic [DIV_VW-1:0] d_reg, d_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_VW:0]   shifted;
    logic [DIV_VW+1:0] diff;
    logic              ge;

    // one trial subtraction per step
    always_comb
    begin
        shifted = {r_reg, q_reg[DIV_DW-1]};
        diff    = {1'b0, shifted} - {2'b00, d_reg};
        ge      = ~diff[DIV_VW+1];
    end

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = busy_reg && (cnt_reg == DIV_CW'(1));
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DIV_DW-2:0], ge};
            r_next   = ge ? diff[DIV_VW-1:0] : shifted[DIV_VW-1:0];
            cnt_next = cnt_reg - DIV_CW'(1);
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/mfic_datapath.sv =====
// datapath: config registers, rule table, membership, aggregation and centroid
module mfic_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mfic_pkg::in_item_t              in_item,
    input  mfic_pkg::dp_cmd_t               cmd,
    output mfic_pkg::dp_status_t            status,
    input  logic                            cfg_we,
    input  logic [mfic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfic_pkg::CFG_DATA_W-1:0] cfg_data,
    output mfic_pkg::out_item_t             out_item
);
    import mfic_pkg::*;

    // truncate toward zero to whole units
    function automatic logic signed [COORD_W-1:0] trunc_unit(input logic signed [COORD_W-1:0] v);
        logic [7:0] whole;
        begin
            whole = v[COORD_W-1:8];
            if (v[COORD_W-1] && (v[7:0] != 8'd0))
            begin
                whole = whole + 8'd1;
            end
            trunc_unit = {whole, 8'd0};
        end
    endfunction

    logic signed [COORD_W-1:0] out_min_reg, out_max_reg;
    logic [SAMP_W-1:0]         samples_reg;
    logic [NR_W-1:0]           rules_reg;

    logic signed [COORD_W-1:0] a_reg, b_reg, x_reg;
    logic [MU_W-1:0]           mu_reg, mua_reg, m_reg, prev_reg;
    logic [MU_W-1:0]           alpha_reg [MAX_RULES];
    logic [SUM_W-1:0]          sum_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [NS_W-1:0]           ns_reg;
    logic [NS_W-1:0]           pl_reg;
    logic [RN_W-1:0]           rn_reg;
    out_item_t                 res_reg, out_reg;

    logic [NR_W-1:0]           nr;
    logic [SAMP_W-1:0]         n_eff;
    logic signed [COORD_W:0]   span;
    logic [COORD_W-1:0]        range;

    // effective configuration
    always_comb
    begin
        nr    = (rules_reg > NR_W'(MAX_RULES)) ? NR_W'(MAX_RULES) : rules_reg;
        n_eff = (samples_reg == '0) ? SAMP_W'(1) : samples_reg;
        span  = {out_max_reg[COORD_W-1], out_max_reg} - {out_min_reg[COORD_W-1], out_min_reg};
        range = span[COORD_W-1:0];
    end

    // rule table
    logic               tbl_we;
    logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
    trap_t              wr_trap, rd_trap;
    logic [ENTRY_W-1:0] rd_word;

    always_comb
    begin
        tbl_we = cmd.accept && (in_item.cmd == CMD_LOAD)
            && (in_item.which_set == SET_A || in_item.which_set == SET_B
                || in_item.which_set == SET_C)
            && ({1'b0, in_item.rule_index} < 5'(MAX_RULES));
        tbl_waddr = TBL_AW'((TBL_AW'(in_item.rule_index) << 1) + TBL_AW'(in_item.rule_index)
            + TBL_AW'(in_item.which_set));
        tbl_raddr = TBL_AW'((TBL_AW'(cmd.rule) << 1) + TBL_AW'(cmd.rule) + TBL_AW'(cmd.phase));
        wr_trap.c1 = in_item.corner_one;
        wr_trap.c2 = in_item.corner_two;
        wr_trap.c3 = in_item.corner_three;
        wr_trap.c4 = in_item.corner_four;
        wr_trap.h  = in_item.set_height;
    end

    mfic_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (wr_trap),
        .raddr (tbl_raddr),
        .rdata (rd_word)
    );

    assign rd_trap = trap_t'(rd_word);

    // trapezoid membership classification
    logic signed [COORD_W-1:0] xm;
    logic                      flat, left, right, mem_div;
    logic signed [COORD_W:0]   dnum, dden;
    logic [MU_W-1:0]           mu_now;
    logic [2*MU_W-1:0]         mprod;

    always_comb
    begin
        case (cmd.phase)
            SET_A:   xm = a_reg;
            SET_B:   xm = b_reg;
            default: xm = x_reg;
        endcase
        flat  = (xm >= rd_trap.c2) && (xm <= rd_trap.c3);
        left  = (xm > rd_trap.c1) && (xm < rd_trap.c2);
        right = (xm > rd_trap.c3) && (xm < rd_trap.c4);
        mem_div = !flat && (left || right);
        if (left)
        begin
            dnum = {xm[COORD_W-1], xm} - {rd_trap.c1[COORD_W-1], rd_trap.c1};
            dden = {rd_trap.c2[COORD_W-1], rd_trap.c2} - {rd_trap.c1[COORD_W-1], rd_trap.c1};
        end
        else
        begin
            dnum = {rd_trap.c4[COORD_W-1], rd_trap.c4} - {xm[COORD_W-1], xm};
            dden = {rd_trap.c4[COORD_W-1], rd_trap.c4} - {rd_trap.c3[COORD_W-1], rd_trap.c3};
        end
        mprod  = rd_trap.h * dnum[COORD_W-1:0];
        mu_now = flat ? rd_trap.h : '0;
    end

    // shared divider operand selection
    logic              div_start, div_done;
    logic [DIV_CW-1:0] div_steps;
    logic [DIV_DW-1:0] div_dividend, div_quot;
    logic [DIV_VW-1:0] div_divisor;
    logic [23:0]       xprod;

    always_comb
    begin
        xprod        = range * cmd.idx;
        div_start    = 1'b0;
        div_steps    = DIV_STEPS_MEM;
        div_dividend = {mprod, (DIV_DW - 2 * MU_W)'(0)};
        div_divisor  = DIV_VW'(dden[COORD_W-1:0]);
        case (cmd.op)
            OP_MEM:
            begin
                div_start = mem_div;
            end
            OP_XDIV:
            begin
                div_start    = 1'b1;
                div_steps    = DIV_STEPS_X;
                div_dividend = {xprod, (DIV_DW - 24)'(0)};
                div_divisor  = DIV_VW'(n_eff);
            end
            OP_FIN3:
            begin
                div_start    = 1'b1;
                div_steps    = DIV_STEPS_FIN;
                div_dividend = DIV_DW'(rn_reg) + DIV_DW'(ns_reg);
                div_divisor  = {ns_reg, 1'b0};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    mfic_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // clipping, aggregation and accumulation terms
    logic [MU_W-1:0]   alpha_sel, clip, alpha_new;
    logic [MU_W:0]     s_term;
    logic [8:0]        odd;
    logic [25:0]       wprod;
    logic [NS_W-1:0]   ns_prod, pl_prod, ph_prod;

    always_comb
    begin
        alpha_sel = alpha_reg[cmd.rule];
        clip      = (mu_reg < alpha_sel) ? mu_reg : alpha_sel;
        alpha_new = (mua_reg < mu_reg) ? mua_reg : mu_reg;
        s_term    = {1'b0, prev_reg} + {1'b0, m_reg};
        odd       = {cmd.idx, 1'b0} - 9'd1;
        wprod     = odd * s_term;
        ns_prod   = n_eff * sum_reg;
        pl_prod   = range * num_reg[16:0];
        ph_prod   = range * num_reg[NUM_W-1:17];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_min_reg <= 16'sd0;
            out_max_reg <= 16'sd25600;
            samples_reg <= 8'd100;
            rules_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OUT_MIN:      out_min_reg <= cfg_data;
                CFG_OUT_MAX:      out_max_reg <= cfg_data;
                CFG_SAMPLE_COUNT: samples_reg <= cfg_data[SAMP_W-1:0];
                CFG_RULES_IN_USE: rules_reg   <= cfg_data[NR_W-1:0];
                default:          rules_reg   <= rules_reg;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (in_item.cmd == CMD_EVAL))
        begin
            a_reg    <= trunc_unit(in_item.crisp_a);
            b_reg    <= trunc_unit(in_item.crisp_b);
            sum_reg  <= '0;
            num_reg  <= '0;
            prev_reg <= '0;
        end
        case (cmd.op)
            OP_RES_EMPTY:
            begin
                res_reg.centroid_value <= '0;
                res_reg.empty_area     <= 1'b1;
            end
            OP_MEM:
            begin
                if (!mem_div)
                begin
                    mu_reg <= mu_now;
                end
            end
            OP_MEM_WAIT:
            begin
                if (div_done)
                begin
                    mu_reg <= div_quot[MU_W-1:0];
                end
            end
            OP_SAVE_A:
            begin
                mua_reg <= mu_reg;
            end
            OP_ALPHA:
            begin
                alpha_reg[cmd.rule] <= alpha_new;
            end
            OP_CLIP:
            begin
                if (clip > m_reg)
                begin
                    m_reg <= clip;
                end
            end
            OP_XWAIT:
            begin
                if (div_done)
                begin
                    x_reg <= out_min_reg + $signed(div_quot[COORD_W-1:0]);
                    m_reg <= '0;
                end
            end
            OP_ACCUM:
            begin
                if (cmd.idx != '0)
                begin
                    sum_reg <= sum_reg + SUM_W'(s_term);
                    num_reg <= num_reg + NUM_W'(wprod);
                end
                prev_reg <= m_reg;
            end
            OP_FIN1:
            begin
                ns_reg <= ns_prod;
                pl_reg <= pl_prod;
            end
            OP_FIN2:
            begin
                rn_reg <= {ph_prod, 17'd0} + RN_W'(pl_reg);
            end
            OP_FIN_WAIT:
            begin
                if (div_done)
                begin
                    res_reg.centroid_value <= out_min_reg + $signed(div_quot[COORD_W-1:0]);
                    res_reg.empty_area     <= 1'b0;
                end
            end
            default:
            begin
                m_reg <= m_reg;
            end
        endcase
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // status back to the controller
    always_comb
    begin
        status.div_done = div_done;
        status.mem_div  = mem_div;
        status.trivial  = (nr == '0) || !(out_max_reg > out_min_reg);
        status.sum_zero = (sum_reg == '0);
        status.rules    = nr;
        status.samples  = n_eff;
    end

    assign out_item = out_reg;

endmodule

// ===== src/mfic_ctrl.sv =====
// controller: sequences rules, samples and the final division
module mfic_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_eval,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  mfic_pkg::dp_status_t status,
    output mfic_pkg::dp_cmd_t    cmd
);
    import mfic_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_MEM,
        S_WAIT,
        S_USE,
        S_XDIV,
        S_XWAIT,
        S_ACCUM,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_FWAIT,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [NR_W-1:0]   r_reg, r_next;
    logic [SAMP_W-1:0] i_reg, i_next;
    logic [1:0]        phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic              last_rule;

    always_comb
    begin
        last_rule      = (r_reg + NR_W'(1)) == status.rules;
        state_next     = state_reg;
        r_next         = r_reg;
        i_next         = i_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.accept     = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.phase      = phase_reg;
        cmd.rule       = r_reg[RULE_W-1:0];
        cmd.idx        = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_eval)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (status.trivial)
                begin
                    cmd.op     = OP_RES_EMPTY;
                    state_next = S_DONE;
                end
                else
                begin
                    r_next     = '0;
                    phase_next = SET_A;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.op     = OP_RD;
                state_next = S_MEM;
            end
            S_MEM:
            begin
                cmd.op     = OP_MEM;
                state_next = status.mem_div ? S_WAIT : S_USE;
            end
            S_WAIT:
            begin
                cmd.op = OP_MEM_WAIT;
                if (status.div_done)
                begin
                    state_next = S_USE;
                end
            end
            S_USE:
            begin
                state_next = S_RD;
                if (phase_reg == SET_A)
                begin
                    cmd.op     = OP_SAVE_A;
                    phase_next = SET_B;
                end
                else if (phase_reg == SET_B)
                begin
                    cmd.op     = OP_ALPHA;
                    phase_next = SET_A;
                    r_next     = r_reg + NR_W'(1);
                    if (last_rule)
                    begin
                        i_next     = '0;
                        state_next = S_XDIV;
                    end
                end
                else
                begin
                    cmd.op = OP_CLIP;
                    r_next = r_reg + NR_W'(1);
                    if (last_rule)
                    begin
                        state_next = S_ACCUM;
                    end
                end
            end
            S_XDIV:
            begin
                cmd.op     = OP_XDIV;
                state_next = S_XWAIT;
            end
            S_XWAIT:
            begin
                cmd.op = OP_XWAIT;
                if (status.div_done)
                begin
                    r_next     = '0;
                    phase_next = SET_C;
                    state_next = S_RD;
                end
            end
            S_ACCUM:
            begin
                cmd.op = OP_ACCUM;
                if (i_reg == status.samples)
                begin
                    state_next = S_FIN1;
                end
                else
                begin
                    i_next     = i_reg + SAMP_W'(1);
                    state_next = S_XDIV;
                end
            end
            S_FIN1:
            begin
                if (status.sum_zero)
                begin
                    cmd.op     = OP_RES_EMPTY;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_FIN1;
                    state_next = S_FIN2;
                end
            end
            S_FIN2:
            begin
                cmd.op     = OP_FIN2;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                cmd.op     = OP_FIN3;
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                cmd.op = OP_FIN_WAIT;
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            r_reg         <= '0;
            i_reg         <= '0;
            phase_reg     <= SET_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            i_reg         <= i_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/mamdani_fuzzy_infer_centroid.sv =====
// top level of the two-input min-max fuzzy controller with centroid output
//
// Input channel (in_valid, in_stall, in_item): a load item (cmd 0) writes one
// trapezoid into the rule table and gives no result. An evaluate item (cmd 1)
// gives exactly one result item on the output channel (out_valid, out_stall,
// out_item).
// Items are worked one at a time; in_stall is high while an evaluation runs.
// A membership on a flat part or outside the set needs no division; one on a
// slope uses the single shared 1-bit-per-step divider, which sets the rate.
// With no rules in use or an empty universe the result is empty and no rule
// is evaluated.
// Reset clears the controller and restores the configuration registers; the
// rule table holds garbage until loaded.
// A finished result waits in the output register while out_stall is high,
// and the next item is taken meanwhile.
module mamdani_fuzzy_infer_centroid (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mfic_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mfic_pkg::out_item_t             out_item,
    input  logic                            cfg_we,
    input  logic [mfic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfic_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mfic_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    mfic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_eval   (in_item.cmd == CMD_EVAL),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and storage
    mfic_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_item  (out_item)
    );

endmodule

// ===== src/mfic_checker.sv =====
// port-level checker for the fuzzy inference block and its bind
`include "mamdani_fuzzy_infer_centroid_defines.svh"

module mfic_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input mfic_pkg::in_item_t  in_item,
    input logic                out_valid,
    input logic                out_stall,
    input mfic_pkg::out_item_t out_item
);
    import mfic_pkg::*;

    // a stalled result stays offered
    `MFIC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // a stalled result keeps its value
    `MFIC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item), "result changed while stalled")

    // an accepted evaluate item makes the block busy
    `MFIC_ASSERT_NEXT(a_eval_busy, in_valid && !in_stall && in_item.cmd == CMD_EVAL, in_stall, "evaluate item did not stall input")

    // an empty-area result carries zero
    `MFIC_ASSERT_NOW(a_empty_zero, out_valid && out_item.empty_area, out_item.centroid_value == 16'sd0, "empty result not zero")

endmodule

bind mamdani_fuzzy_infer_centroid mfic_checker u_mfic_checker (.*);
